### hdl/msfa_pkg.sv
// ----------------------------------------------------------------------------
// msfa_pkg
// Shared constants, types and helpers for the sample frame assembler.
// ----------------------------------------------------------------------------
package msfa_pkg;

    localparam int SLOT_N     = 12;
    localparam int SLOT_AW    = 4;
    localparam int SAMPLE_W   = 24;
    localparam int BYTE_W     = 8;
    localparam int CHAN_W     = 5;
    localparam int CFG_IDX_W  = 1;

    localparam logic [SLOT_AW-1:0]  SLOT_LAST   = 4'd11;
    localparam logic [SLOT_N-1:0]   ALL_FILLED  = 12'hFFF;
    localparam logic [CHAN_W-1:0]   CHAN_A_LO   = 5'd9;
    localparam logic [CHAN_W-1:0]   CHAN_A_HI   = 5'd15;
    localparam logic [CHAN_W-1:0]   CHAN_B_LO   = 5'd17;
    localparam logic [CHAN_W-1:0]   CHAN_B_HI   = 5'd21;
    localparam logic [SLOT_AW-1:0]  SLOT_B_BASE = 4'd7;

    localparam logic [BYTE_W-1:0]   HDR_FIRST_RST  = 8'hAA;
    localparam logic [BYTE_W-1:0]   HDR_SECOND_RST = 8'h55;

    localparam logic [CFG_IDX_W-1:0] CFG_HDR_FIRST  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HDR_SECOND = 1'b1;

    typedef struct packed {
        logic                valid;
        logic [SLOT_AW-1:0]  slot;
    } t_slot_map;

    // Channel number to slot; unmapped channels come back not valid
    function automatic t_slot_map map_channel(input logic [CHAN_W-1:0] chan);
        t_slot_map m;
        logic [CHAN_W-1:0] offs;
        m.valid = 1'b0;
        m.slot  = '0;
        offs    = '0;
        if (chan >= CHAN_A_LO && chan <= CHAN_A_HI) begin
            offs    = chan - CHAN_A_LO;
            m.valid = 1'b1;
            m.slot  = offs[SLOT_AW-1:0];
        end else if (chan >= CHAN_B_LO && chan <= CHAN_B_HI) begin
            offs    = chan - CHAN_B_LO;
            m.valid = 1'b1;
            m.slot  = SLOT_B_BASE + offs[SLOT_AW-1:0];
        end
        return m;
    endfunction

endpackage

### hdl/msfa_ram.sv
// ----------------------------------------------------------------------------
// msfa_ram
// Generic simple dual-port RAM, one write port, registered read.
// ----------------------------------------------------------------------------
module msfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/multichannel_sample_frame_assembler.sv
// ----------------------------------------------------------------------------
// multichannel_sample_frame_assembler
// Gathers 12 converter channels into slots and streams out a 38-byte frame.
// ----------------------------------------------------------------------------
// Frame start: the completing readout moves the sequencer to its header
//   state, which puts the first frame beat on the output register once that
//   register is free.
// Throughput: one readout per cycle while a group fills; a frame sends its
//   38 beats, with a sample-RAM read state before each slot after the first,
//   and no readout is taken while it runs.
// Reset: synchronous, active low; clears the group and restores the headers.
//   Sample RAM contents are not reset.
// ----------------------------------------------------------------------------
module multichannel_sample_frame_assembler
    import msfa_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // readout channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [BYTE_W-1:0]     i_adc_status,
    input  logic [SAMPLE_W-1:0]   i_sample_value,
    // frame channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [BYTE_W-1:0]     o_frame_byte,
    output logic                  o_frame_last,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [BYTE_W-1:0]     i_cfg_data
);

    // Sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;  // collecting readouts
    localparam logic [1:0] S_HDR  = 2'd1;  // two header beats
    localparam logic [1:0] S_LOAD = 2'd2;  // wait for slot read data
    localparam logic [1:0] S_DATA = 2'd3;  // three sample beats, MSB first

    logic [1:0]          r_state, n_state;
    logic [SLOT_N-1:0]   r_filled, n_filled;
    logic [SLOT_AW-1:0]  r_count, n_count;
    logic [SLOT_AW-1:0]  r_slot, n_slot;    // slot being read out
    logic [1:0]          r_phase, n_phase;  // beat within header or sample
    logic [BYTE_W-1:0]   r_hdr_first, r_hdr_second;

    // Output register
    logic                r_ovalid, n_ovalid;
    logic [BYTE_W-1:0]   r_obyte, n_obyte;
    logic                r_olast, n_olast;

    logic                w_accept;
    t_slot_map           w_map;
    logic                w_store;
    logic [SLOT_N-1:0]   w_set;
    logic [SLOT_AW-1:0]  w_count_inc;
    logic                w_complete;
    logic                w_can_load;
    logic [SAMPLE_W-1:0] w_rdata;

    // ------------------------------------------------------------------
    // Readout intake
    // ------------------------------------------------------------------
    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_map       = map_channel(i_adc_status[CHAN_W-1:0]);
    // first sample for an empty slot only; repeats fall away
    assign w_store     = w_accept && w_map.valid && !r_filled[w_map.slot];
    assign w_set       = r_filled | (SLOT_N'(1) << w_map.slot);
    assign w_count_inc = r_count + SLOT_AW'(1);
    assign w_complete  = w_store && (w_count_inc == SLOT_AW'(SLOT_N));

    // Sample store; read address follows the readout pointer, so data is
    // valid the cycle after r_slot moves. Writes only happen in S_IDLE.
    msfa_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (SLOT_N)
    ) u_samples (
        .i_clk   (i_clk),
        .i_we    (w_store),
        .i_waddr (w_map.slot),
        .i_wdata (i_sample_value),
        .i_raddr (r_slot),
        .o_rdata (w_rdata)
    );

    // Output register may take a new beat when empty or being drained
    assign w_can_load = !r_ovalid || i_out_ready;

    // ------------------------------------------------------------------
    // Next-state logic
    // ------------------------------------------------------------------
    always_comb begin
        n_state  = r_state;
        n_filled = r_filled;
        n_count  = r_count;
        n_slot   = r_slot;
        n_phase  = r_phase;
        n_ovalid = r_ovalid && !i_out_ready;
        n_obyte  = r_obyte;
        n_olast  = r_olast;

        case (r_state)
            S_IDLE: begin
                if (w_store) begin
                    if (w_complete) begin
                        // group done: clear it now, inputs stay blocked
                        n_filled = '0;
                        n_count  = '0;
                        n_slot   = '0;
                        n_phase  = '0;
                        n_state  = S_HDR;
                    end else begin
                        n_filled = w_set;
                        n_count  = w_count_inc;
                    end
                end
            end
            S_HDR: begin
                if (w_can_load) begin
                    n_ovalid = 1'b1;
                    n_olast  = 1'b0;
                    if (r_phase == 2'd0) begin
                        n_obyte = r_hdr_first;
                        n_phase = 2'd1;
                    end else begin
                        n_obyte = r_hdr_second;
                        n_phase = 2'd0;
                        n_state = S_DATA;  // slot 0 data already read
                    end
                end
            end
            S_LOAD: begin
                n_state = S_DATA;
            end
            S_DATA: begin
                if (w_can_load) begin
                    n_ovalid = 1'b1;
                    n_olast  = 1'b0;
                    case (r_phase)
                        2'd0:    n_obyte = w_rdata[23:16];
                        2'd1:    n_obyte = w_rdata[15:8];
                        default: n_obyte = w_rdata[7:0];
                    endcase
                    if (r_phase == 2'd2) begin
                        n_phase = 2'd0;
                        if (r_slot == SLOT_LAST) begin
                            n_olast = 1'b1;
                            n_state = S_IDLE;
                        end else begin
                            n_slot  = r_slot + SLOT_AW'(1);
                            n_state = S_LOAD;
                        end
                    end else begin
                        n_phase = r_phase + 2'd1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_filled     <= '0;
            r_count      <= '0;
            r_slot       <= '0;
            r_phase      <= '0;
            r_ovalid     <= 1'b0;
            r_hdr_first  <= HDR_FIRST_RST;
            r_hdr_second <= HDR_SECOND_RST;
        end else begin
            r_state  <= n_state;
            r_filled <= n_filled;
            r_count  <= n_count;
            r_slot   <= n_slot;
            r_phase  <= n_phase;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_HDR_FIRST:  r_hdr_first  <= i_cfg_data;
                    CFG_HDR_SECOND: r_hdr_second <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_obyte <= n_obyte;
        r_olast <= n_olast;
    end

    assign o_out_valid  = r_ovalid;
    assign o_frame_byte = r_obyte;
    assign o_frame_last = r_olast;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == SLOT_AW'($countones(r_filled)))
        else $error("fill count out of step with slot flags");

    a_frame_on_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && n_state == S_HDR) |-> (w_set == ALL_FILLED))
        else $error("frame started before all slots filled");

    a_last_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DATA && n_olast && n_ovalid && w_can_load) |=> (r_state == S_IDLE))
        else $error("last beat issued without returning to idle");

    a_no_write_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !w_store)
        else $error("sample store written during frame readout");

endmodule
